FILE: hdl/lrqsh_pkg.sv
package lrqsh_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_HANDLE_BITS = 16;

  localparam int MODE_W   = 2;
  localparam int HANDLE_W = 16;
  localparam int COUNT_W  = 7;
  localparam int KIND_W   = 3;

  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEAL = 2'd2;

  localparam logic [KIND_W-1:0] KIND_PUSHED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POPPED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EVICTED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOLEN  = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  // One result word handed from the controller to the output register.
  typedef struct packed {
    logic                load;
    logic                from_mem;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  run;
    logic                last;
  } emit_t;

endpackage

FILE: hdl/lrqsh_cmd_if.sv
interface lrqsh_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [lrqsh_pkg::MODE_W-1:0]   mode;
  logic [lrqsh_pkg::HANDLE_W-1:0] handle_in;
  logic [lrqsh_pkg::COUNT_W-1:0]  max_take;

  modport source (output valid, mode, handle_in, max_take, input ready);
  modport sink (input valid, mode, handle_in, max_take, output ready);
endinterface

FILE: hdl/lrqsh_res_if.sv
interface lrqsh_res_if;
  logic                           valid;
  logic                           ready;
  logic [lrqsh_pkg::KIND_W-1:0]   kind;
  logic [lrqsh_pkg::HANDLE_W-1:0] handle_out;
  logic [lrqsh_pkg::COUNT_W-1:0]  run_count;
  logic                           last;

  modport source (output valid, kind, handle_out, run_count, last, input ready);
  modport sink (input valid, kind, handle_out, run_count, last, output ready);
endinterface

FILE: hdl/lrqsh_ram.sv
module lrqsh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/lrqsh_ctrl.sv
module lrqsh_ctrl #(
  parameter int QUEUE_DEPTH = lrqsh_pkg::DEF_QUEUE_DEPTH,
  parameter int STORE_BITS  = lrqsh_pkg::DEF_HANDLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  lrqsh_cmd_if.sink                      cmd,
  input  logic                           out_free,
  output lrqsh_pkg::emit_t               emit,
  output logic                           wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  output logic [STORE_BITS-1:0]          wr_data,
  output logic                           rd_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int HALF = QUEUE_DEPTH / 2;
  localparam logic [lrqsh_pkg::HANDLE_W-1:0] HMASK =
    lrqsh_pkg::HANDLE_W'((64'd1 << STORE_BITS) - 64'd1);

  lrqsh_pkg::state_t state, state_next;
  logic [PW-1:0]                       head, head_next;
  logic [PW-1:0]                       tail, tail_next;
  logic [CW-1:0]                       cnt, cnt_next;
  logic [lrqsh_pkg::COUNT_W-1:0]       rem, rem_next;
  logic                                tail_item, tail_item_next;
  logic                                rd_valid, rd_valid_next;
  logic [lrqsh_pkg::KIND_W-1:0]        kind, kind_next;
  logic [lrqsh_pkg::HANDLE_W-1:0]      hold, hold_next;
  logic [lrqsh_pkg::COUNT_W-1:0]       run, run_next;

  logic [PW-1:0]                       head_inc;
  logic [PW-1:0]                       tail_inc;
  logic                                full;
  logic                                empty;
  logic [lrqsh_pkg::COUNT_W-1:0]       half_up;
  logic [lrqsh_pkg::COUNT_W-1:0]       steal_n;
  logic [lrqsh_pkg::HANDLE_W-1:0]      h_masked;

  assign head_inc  = (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + PW'(1);
  assign tail_inc  = (tail == PW'(QUEUE_DEPTH - 1)) ? '0 : tail + PW'(1);
  assign full      = (cnt == CW'(QUEUE_DEPTH));
  assign empty     = (cnt == '0);
  assign half_up   = (lrqsh_pkg::COUNT_W'(cnt) + lrqsh_pkg::COUNT_W'(1)) >> 1;
  assign steal_n   = (half_up > cmd.max_take) ? cmd.max_take : half_up;
  assign h_masked  = cmd.handle_in & HMASK;

  assign cmd.ready = (state == lrqsh_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lrqsh_pkg::ST_IDLE;
      head     <= '0;
      tail     <= '0;
      cnt      <= '0;
      rem      <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      cnt      <= cnt_next;
      rem      <= rem_next;
      rd_valid <= rd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    tail_item <= tail_item_next;
    kind      <= kind_next;
    hold      <= hold_next;
    run       <= run_next;
  end

  always_comb begin
    logic                          op;
    logic [lrqsh_pkg::COUNT_W-1:0] n_rd;
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    cnt_next       = cnt;
    rem_next       = rem;
    rd_valid_next  = rd_valid;
    tail_item_next = tail_item;
    kind_next      = kind;
    hold_next      = hold;
    run_next       = run;
    wr_en          = 1'b0;
    wr_addr        = tail;
    wr_data        = h_masked[STORE_BITS-1:0];
    rd_en          = 1'b0;
    rd_addr        = head;
    emit           = '0;
    op             = 1'b0;
    n_rd           = '0;

    case (state)
      lrqsh_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          op = 1'b1;
          case (cmd.mode)
            lrqsh_pkg::MODE_PUSH: begin
              if (!full) begin
                wr_en          = 1'b1;
                tail_next      = tail_inc;
                cnt_next       = cnt + CW'(1);
                kind_next      = lrqsh_pkg::KIND_PUSHED;
                hold_next      = '0;
                run_next       = 7'd1;
                tail_item_next = 1'b1;
              end else begin
                // Full ring: the oldest half goes out first, then the new
                // handle, which is never stored.
                n_rd           = lrqsh_pkg::COUNT_W'(HALF);
                kind_next      = lrqsh_pkg::KIND_EVICTED;
                hold_next      = h_masked;
                run_next       = lrqsh_pkg::COUNT_W'(HALF + 1);
                tail_item_next = 1'b1;
              end
            end
            lrqsh_pkg::MODE_POP: begin
              if (empty) begin
                kind_next      = lrqsh_pkg::KIND_EMPTY;
                hold_next      = '0;
                run_next       = 7'd1;
                tail_item_next = 1'b1;
              end else begin
                n_rd           = 7'd1;
                kind_next      = lrqsh_pkg::KIND_POPPED;
                run_next       = 7'd1;
                tail_item_next = 1'b0;
              end
            end
            lrqsh_pkg::MODE_STEAL: begin
              if (steal_n == '0) begin
                kind_next      = lrqsh_pkg::KIND_EMPTY;
                hold_next      = '0;
                run_next       = 7'd1;
                tail_item_next = 1'b1;
              end else begin
                n_rd           = steal_n;
                kind_next      = lrqsh_pkg::KIND_STOLEN;
                run_next       = steal_n;
                tail_item_next = 1'b0;
              end
            end
            default: begin
              op = 1'b0;
            end
          endcase

          if (op) begin
            rem_next = n_rd;
            if (n_rd != '0) begin
              rd_en         = 1'b1;
              rd_valid_next = 1'b1;
              state_next    = lrqsh_pkg::ST_BURST;
            end else if (out_free) begin
              // A single word with no memory read goes straight out.
              emit.load   = 1'b1;
              emit.kind   = kind_next;
              emit.handle = hold_next;
              emit.run    = run_next;
              emit.last   = 1'b1;
            end else begin
              state_next = lrqsh_pkg::ST_BURST;
            end
          end
        end
      end

      lrqsh_pkg::ST_BURST: begin
        if (rem != '0) begin
          if (rd_valid && out_free) begin
            emit.load     = 1'b1;
            emit.from_mem = 1'b1;
            emit.kind     = kind;
            emit.run      = run;
            emit.last     = (rem == 7'd1) && !tail_item;
            head_next     = head_inc;
            cnt_next      = cnt - CW'(1);
            rem_next      = rem - 7'd1;
            if (rem != 7'd1) begin
              rd_en   = 1'b1;
              rd_addr = head_inc;
            end else begin
              rd_valid_next = 1'b0;
              if (!tail_item) begin
                state_next = lrqsh_pkg::ST_IDLE;
              end
            end
          end
        end else if (out_free) begin
          emit.load   = 1'b1;
          emit.kind   = kind;
          emit.handle = hold;
          emit.run    = run;
          emit.last   = 1'b1;
          state_next  = lrqsh_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = lrqsh_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("read and write of the ring in one cycle");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit.load |-> out_free)
    else $error("result word loaded into an occupied output register");

  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    (state == lrqsh_pkg::ST_BURST && rem == '0) |-> tail_item)
    else $error("burst has no reads left and no final word");

  a_read_ready: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> rd_valid)
    else $error("issued read not marked as pending");
`endif

endmodule

FILE: hdl/lrqsh_out.sv
module lrqsh_out #(
  parameter int STORE_BITS = lrqsh_pkg::DEF_HANDLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrqsh_pkg::emit_t      emit,
  input  logic [STORE_BITS-1:0] rd_data,
  output logic                  out_free,
  lrqsh_res_if.source           res
);

  logic                           valid;
  logic [lrqsh_pkg::KIND_W-1:0]   kind;
  logic [lrqsh_pkg::HANDLE_W-1:0] handle;
  logic [lrqsh_pkg::COUNT_W-1:0]  run;
  logic                           last;

  assign out_free = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (emit.load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      kind   <= emit.kind;
      handle <= emit.from_mem ? lrqsh_pkg::HANDLE_W'(rd_data) : emit.handle;
      run    <= emit.run;
      last   <= emit.last;
    end
  end

  assign res.valid      = valid;
  assign res.kind       = kind;
  assign res.handle_out = handle;
  assign res.run_count  = run;
  assign res.last       = last;

endmodule

FILE: hdl/local_run_queue_steal_half.sv
// Channel  Dir  Payload                                  Transfer
// cmd      in   mode, handle_in, max_take                valid && ready
// res      out  kind, handle_out, run_count, last        valid && ready
//
// Push, failed pop and empty steal emit one word with no ring read; a pop that hits
// reads the ring. A burst of n words is read through the registered read port of the
// ring memory; an eviction adds one word for the new handle.
// cmd is held off while a burst is in progress; a stall on res freezes the burst.
// Synchronous reset empties the queue; no clearing pass is needed.
module local_run_queue_steal_half #(
  parameter int QUEUE_DEPTH = lrqsh_pkg::DEF_QUEUE_DEPTH,
  parameter int HANDLE_BITS = lrqsh_pkg::DEF_HANDLE_BITS
) (
  input logic          clk,
  input logic          rst,
  lrqsh_cmd_if.sink    cmd,
  lrqsh_res_if.source  res
);

  localparam int STORE_BITS = (HANDLE_BITS < lrqsh_pkg::HANDLE_W) ?
                              HANDLE_BITS : lrqsh_pkg::HANDLE_W;
  localparam int PW = $clog2(QUEUE_DEPTH);

  lrqsh_pkg::emit_t      emit;
  logic                  out_free;
  logic                  wr_en;
  logic [PW-1:0]         wr_addr;
  logic [STORE_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [PW-1:0]         rd_addr;
  logic [STORE_BITS-1:0] rd_data;

  lrqsh_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STORE_BITS  (STORE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .out_free (out_free),
    .emit     (emit),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr)
  );

  lrqsh_ram #(
    .WIDTH (STORE_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lrqsh_out #(
    .STORE_BITS (STORE_BITS)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit),
    .rd_data  (rd_data),
    .out_free (out_free),
    .res      (res)
  );

endmodule
